// ===== sv/uart_drb_pkg.sv =====
// shared types and constants for the uart dual ring buffer
// no dependencies; imported by uart_drb_ring and uart_dual_ring_buffer_top
`timescale 1ns / 1ps
`default_nettype none

package uart_drb_pkg;

    localparam int STAT_W          = 8;
    localparam int BYTE_W          = 8;
    localparam int RX_CAPACITY_DEF = 128;
    localparam int TX_CAPACITY_DEF = 64;

    typedef enum logic [2:0] {
        ACT_RX_BYTE    = 3'd0,
        ACT_HOST_READ  = 3'd1,
        ACT_HOST_WRITE = 3'd2,
        ACT_LINE_SEND  = 3'd3,
        ACT_FLUSH_RX   = 3'd4
    } action_t;

    // per-cycle request into one ring, already qualified by the transfer
    typedef struct packed {
        logic push;
        logic pop;
        logic flush;
    } ring_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ring_stat_t;

endpackage

`default_nettype wire

// ===== sv/uart_dual_ring_buffer_top.sv =====
// uart dual ring buffer: receive and transmit byte rings with result stage
// depends on uart_drb_pkg and uart_drb_ring
// a result is registered and appears on the master side in the cycle after the input transfer
// throughput: one action per cycle while results are taken, each action makes at most one access to one ring memory
// rings and output register stall together while a result is not taken
// reset (rst_n low, asynchronous): both rings empty, transmit request off, no result
`timescale 1ns / 1ps
`default_nettype none

module uart_dual_ring_buffer_top #(
    parameter int RX_CAPACITY = uart_drb_pkg::RX_CAPACITY_DEF,
    parameter int TX_CAPACITY = uart_drb_pkg::TX_CAPACITY_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_in
    input  wire logic [2:0]  s_tuser,   // [2:0] action
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] data_out, [15:8] rx_fill,
                                        // [23:16] rx_free, [31:24] tx_fill
    output logic [2:0]       m_tuser    // [0] data_valid, [1] rejected, [2] tx_request
);
    import uart_drb_pkg::*;

    localparam int RX_CW = $clog2(RX_CAPACITY + 1);
    localparam int TX_CW = $clog2(TX_CAPACITY + 1);

    // input transfer and decode
    logic       in_xfer;
    action_t    action;
    ring_ctrl_t rx_ctrl;
    ring_ctrl_t tx_ctrl;
    ring_stat_t rx_stat;
    ring_stat_t tx_stat;
    logic [RX_CW-1:0]  rx_count;
    logic [TX_CW-1:0]  tx_count;
    logic [BYTE_W-1:0] rx_rdata;
    logic [BYTE_W-1:0] tx_rdata;

    // result stage
    logic out_valid_reg,  out_valid_next;
    logic out_src_tx_reg, out_src_tx_next;   // which ring supplied the byte
    logic out_dval_reg,   out_dval_next;
    logic out_rej_reg,    out_rej_next;
    logic tx_armed_reg,   tx_armed_next;

    logic [BYTE_W-1:0] data_out;

    // the result register frees up when it is empty or being taken this cycle
    assign s_tready = !out_valid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;
    assign action   = action_t'(s_tuser);

    always_comb
    begin
        rx_ctrl         = '0;
        tx_ctrl         = '0;
        tx_armed_next   = tx_armed_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_src_tx_next = out_src_tx_reg;
        out_dval_next   = out_dval_reg;
        out_rej_next    = out_rej_reg;
        if (in_xfer)
        begin
            out_valid_next  = 1'b1;
            out_src_tx_next = 1'b0;
            out_dval_next   = 1'b0;
            out_rej_next    = 1'b0;
            unique case (action)
                ACT_RX_BYTE:
                begin
                    rx_ctrl.push = 1'b1;
                    out_rej_next = rx_stat.full;
                end
                ACT_HOST_READ:
                begin
                    rx_ctrl.pop   = 1'b1;
                    out_dval_next = !rx_stat.empty;
                end
                ACT_HOST_WRITE:
                begin
                    tx_ctrl.push  = 1'b1;
                    out_rej_next  = tx_stat.full;
                    // armed on every host write, refused or not
                    tx_armed_next = 1'b1;
                end
                ACT_LINE_SEND:
                begin
                    tx_ctrl.pop     = 1'b1;
                    out_src_tx_next = 1'b1;
                    out_dval_next   = !tx_stat.empty;
                    if (tx_stat.empty)
                    begin
                        tx_armed_next = 1'b0;
                    end
                end
                ACT_FLUSH_RX:
                begin
                    rx_ctrl.flush = 1'b1;
                end
                default:
                begin
                    // unused action codes only report status
                end
            endcase
        end
    end

    uart_drb_ring #(
        .CAPACITY (RX_CAPACITY)
    ) u_rx_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (rx_ctrl),
        .wdata (s_tdata),
        .stat  (rx_stat),
        .count (rx_count),
        .rdata (rx_rdata)
    );

    uart_drb_ring #(
        .CAPACITY (TX_CAPACITY)
    ) u_tx_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (tx_ctrl),
        .wdata (s_tdata),
        .stat  (tx_stat),
        .count (tx_count),
        .rdata (tx_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            out_src_tx_reg <= 1'b0;
            out_dval_reg   <= 1'b0;
            out_rej_reg    <= 1'b0;
            tx_armed_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            out_src_tx_reg <= out_src_tx_next;
            out_dval_reg   <= out_dval_next;
            out_rej_reg    <= out_rej_next;
            tx_armed_reg   <= tx_armed_next;
        end
    end

    // counts and the armed flag only move on a transfer, which also reloads
    // the result register, so they always show the state after the shown action
    assign data_out = out_dval_reg ? (out_src_tx_reg ? tx_rdata : rx_rdata) : '0;

    assign m_tvalid       = out_valid_reg;
    assign m_tdata[7:0]   = data_out;
    assign m_tdata[15:8]  = STAT_W'(rx_count);
    assign m_tdata[23:16] = STAT_W'(RX_CAPACITY) - STAT_W'(rx_count);
    assign m_tdata[31:24] = STAT_W'(tx_count);
    assign m_tuser[0]     = out_dval_reg;
    assign m_tuser[1]     = out_rej_reg;
    assign m_tuser[2]     = tx_armed_reg;

    // a result never both delivers a byte and reports a refusal
    a_dval_not_rej: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("result carries a byte and a refusal");

    // fill levels stay within capacity
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_count <= RX_CW'(RX_CAPACITY)) && (tx_count <= TX_CW'(TX_CAPACITY)))
        else $error("ring fill above capacity");

    // a flush empties the receive ring
    a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && action == ACT_FLUSH_RX) |=> (rx_count == '0))
        else $error("receive ring not empty after flush");

    // a host write always arms the transmit request
    a_write_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && action == ACT_HOST_WRITE) |=> tx_armed_reg)
        else $error("transmit request not armed after host write");

endmodule

`default_nettype wire

// ===== sv/uart_drb_ring.sv =====
// one byte ring: head/tail/count registers around a simple dual-port style memory
// depends on uart_drb_pkg
`timescale 1ns / 1ps
`default_nettype none

module uart_drb_ring #(
    parameter int CAPACITY = uart_drb_pkg::RX_CAPACITY_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire uart_drb_pkg::ring_ctrl_t            ctrl,
    input  wire logic [uart_drb_pkg::BYTE_W-1:0]     wdata,
    output uart_drb_pkg::ring_stat_t                 stat,
    output logic [$clog2(CAPACITY+1)-1:0]            count,
    output logic [uart_drb_pkg::BYTE_W-1:0]          rdata
);
    import uart_drb_pkg::*;

    localparam int SLOTS = CAPACITY + 1;
    localparam int PTR_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [BYTE_W-1:0] mem [SLOTS];

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [BYTE_W-1:0] rdata_reg;
    logic              do_push;
    logic              do_pop;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] idx);
        logic [PTR_W-1:0] n;
        begin
            if (idx == PTR_W'(SLOTS - 1))
            begin
                n = '0;
            end
            else
            begin
                n = idx + 1'b1;
            end
            return n;
        end
    endfunction

    assign stat.full  = (count_reg == CNT_W'(CAPACITY));
    assign stat.empty = (count_reg == '0);

    // push writes at head, pop reads at tail; a pop needs a non-empty ring so
    // the two never address the same entry in one cycle
    assign do_push = ctrl.push && !stat.full;
    assign do_pop  = ctrl.pop && !stat.empty;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctrl.flush)
        begin
            tail_next  = head_reg;
            count_next = '0;
        end
        else
        begin
            if (do_push)
            begin
                head_next = advance(head_reg);
            end
            if (do_pop)
            begin
                tail_next = advance(tail_reg);
            end
            if (do_push && !do_pop)
            begin
                count_next = count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // storage and registered read port; read data holds until the next pop
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[head_reg] <= wdata;
        end
        if (do_pop)
        begin
            rdata_reg <= mem[tail_reg];
        end
    end

    assign count = count_reg;
    assign rdata = rdata_reg;

endmodule

`default_nettype wire
